@@ src/key_matrix_scan_debounce_assert.svh @@
// assertion macros for the key matrix scan debounce block
`ifndef KEY_MATRIX_SCAN_DEBOUNCE_ASSERT_SVH
`define KEY_MATRIX_SCAN_DEBOUNCE_ASSERT_SVH
`ifndef SYNTHESIS
`define KMSD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("kmsd assertion failed");
`define KMSD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) ante |=> cons) \
    else $error("kmsd assertion failed");
`else
`define KMSD_ASSERT(lbl, clk, rstn, prop)
`define KMSD_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ src/kmsd_pkg.sv @@
// shared types and constants of the key matrix scan debounce block
`timescale 1ns / 1ps
package kmsd_pkg;

  localparam int SENSE_W    = 8;
  localparam int MAP_IDX_W  = 7;
  localparam int MAP_KEY_W  = 7;
  localparam int ROWS_W     = 4;
  localparam int COLS_W     = 5;
  localparam int PAGE_W     = 8;
  localparam int DCOL_W     = 4;
  localparam int KEYS_W     = 64;
  localparam int CCNT_W     = 6;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 80;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic OP_SCAN      = 1'b0;
  localparam logic OP_MAP_WRITE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS_IN_USE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_NUMBER    = 2'd2;

  localparam logic [ROWS_W-1:0] ROWS_RESET = 4'd8;
  localparam logic [COLS_W-1:0] COLS_RESET = 5'd16;
  localparam logic [PAGE_W-1:0] PAGE_RESET = 8'd0;

  typedef struct packed {
    logic                 we;
    logic [MAP_IDX_W-1:0] index;
    logic [MAP_KEY_W-1:0] key;
  } kmsd_map_wr_t;

endpackage

@@ src/kmsd_ram.sv @@
// generic single write port ram with registered read
`timescale 1ns / 1ps
module kmsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/kmsd_lane.sv @@
// one row lane: key map row storage and key bit decode
`timescale 1ns / 1ps
module kmsd_lane
  import kmsd_pkg::*;
#(
  parameter int ROW         = 0,
  parameter int MAX_COLUMNS = 16,
  parameter int KEY_BITS    = 64,
  parameter int COL_W       = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  kmsd_map_wr_t        wr_i,
  input  logic [COL_W-1:0]    rd_col_i,
  input  logic [COL_W-1:0]    cur_col_i,
  input  logic                hit_i,
  output logic [KEY_BITS-1:0] mask_o
);

  localparam int BASE = ROW * MAX_COLUMNS;

  logic                   sel;
  logic [COL_W-1:0]       waddr;
  logic [MAP_KEY_W-1:0]   ram_rdata;
  logic [MAX_COLUMNS-1:0] valid_q;
  logic                   fwd_q;
  logic [MAP_KEY_W-1:0]   fwd_data_q;
  logic [MAP_KEY_W-1:0]   entry;
  logic                   key_ok;

  assign sel   = wr_i.we && (int'(wr_i.index) >= BASE)
                 && (int'(wr_i.index) < BASE + MAX_COLUMNS);
  assign waddr = COL_W'(int'(wr_i.index) - BASE);

  kmsd_ram #(
    .WIDTH (MAP_KEY_W),
    .DEPTH (MAX_COLUMNS),
    .AW    (COL_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (sel),
    .waddr_i (waddr),
    .wdata_i (wr_i.key),
    .raddr_i (rd_col_i),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      fwd_q   <= 1'b0;
    end else begin
      if (sel) begin
        valid_q[waddr] <= 1'b1;
      end
      fwd_q <= sel && (waddr == rd_col_i);
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= wr_i.key;
  end

  // write in the same cycle as the read is forwarded
  assign entry  = valid_q[cur_col_i] ? (fwd_q ? fwd_data_q : ram_rdata) : '0;
  assign key_ok = (entry != '0) && (entry <= MAP_KEY_W'(KEY_BITS));
  assign mask_o = (hit_i && key_ok) ? (KEY_BITS'(1) << (entry - MAP_KEY_W'(1)))
                                    : '0;

endmodule

@@ src/kmsd_ring.sv @@
// merge of lane key bits into the scan mask ring and debounce AND of all its slots
`timescale 1ns / 1ps
module kmsd_ring #(
  parameter int MAX_ROWS       = 8,
  parameter int DEBOUNCE_SCANS = 4,
  parameter int KEY_BITS       = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [MAX_ROWS-1:0][KEY_BITS-1:0]  masks_i,
  input  logic                               upd_i,
  input  logic                               pass_end_i,
  output logic [KEY_BITS-1:0]                keys_o
);

  localparam int SLOT_W = (DEBOUNCE_SCANS > 1) ? $clog2(DEBOUNCE_SCANS) : 1;

  logic [KEY_BITS-1:0] ring_q [DEBOUNCE_SCANS];
  logic [KEY_BITS-1:0] ring_d [DEBOUNCE_SCANS];
  logic [SLOT_W-1:0]   slot_q;
  logic [SLOT_W-1:0]   slot_d;
  logic [SLOT_W-1:0]   slot_next;
  logic [KEY_BITS-1:0] merged;
  logic [KEY_BITS-1:0] keys;

  always_comb begin
    merged = '0;
    for (int r = 0; r < MAX_ROWS; r++) begin
      merged = merged | masks_i[r];
    end
  end

  assign slot_next = (slot_q == SLOT_W'(DEBOUNCE_SCANS - 1)) ? '0 : slot_q + SLOT_W'(1);
  assign slot_d    = (upd_i && pass_end_i) ? slot_next : slot_q;

  always_comb begin
    keys = '1;
    for (int j = 0; j < DEBOUNCE_SCANS; j++) begin
      ring_d[j] = ring_q[j];
      if (upd_i && (slot_q == SLOT_W'(j))) begin
        ring_d[j] = ring_q[j] | merged;
      end
      keys = keys & ring_d[j];
      if (upd_i && pass_end_i && (slot_next == SLOT_W'(j))) begin
        ring_d[j] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      for (int j = 0; j < DEBOUNCE_SCANS; j++) begin
        ring_q[j] <= '0;
      end
    end else begin
      slot_q <= slot_d;
      for (int j = 0; j < DEBOUNCE_SCANS; j++) begin
        ring_q[j] <= ring_d[j];
      end
    end
  end

  assign keys_o = keys;

endmodule

@@ src/key_matrix_scan_debounce.sv @@
// top level of the key matrix scanner with debounce
//
// Input stream (s_axis): one item per tick or key map write. tuser selects the
// kind: scan tick or map write. A scan tick alternates drive and read phases;
// a read tick samples row_sense through one lane per row, each lane holding
// that row of the key map, and ORs the found key bits into the current slot
// of the scan mask ring. After the last column the ring advances and the AND
// of all slots is reported with the page tag, flagged by m_axis_tuser.
// Output stream (m_axis): exactly one item per input item, in order.
// m_axis_tvalid rises in the cycle after acceptance; one item per cycle
// is sustained, set by the single output register that s_axis_tready follows.
// When the receiver stalls the output item holds and s_axis_tready drops
// until it is taken; a new item is accepted in the cycle the old one leaves.
// Configuration port (rows_in_use, columns_in_use, page_number writes): always
// ready; the user must write only while no item is in flight (not enforced).
// Reset clears the column, phase, ring, key map valid bits and output stage,
// and loads rows 8, columns 16, page 0; no clearing pass is needed.
`timescale 1ns / 1ps
`include "key_matrix_scan_debounce_assert.svh"
module key_matrix_scan_debounce
  import kmsd_pkg::*;
#(
  parameter int MAX_ROWS       = 8,
  parameter int MAX_COLUMNS    = 16,
  parameter int DEBOUNCE_SCANS = 4,
  parameter int KEY_BITS       = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // row_sense[7:0], map_index[14:8], map_key[21:15], zero pad
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // operation
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // drive_column[3:0], drive_on[4], debounced_keys[68:5], report_page[76:69], zero pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // report_valid
  output logic                  m_axis_tuser,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int COL_W    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int ROWS_LIM = (MAX_ROWS < SENSE_W) ? MAX_ROWS : SENSE_W;
  localparam logic [CCNT_W-1:0] MAX_COLS_C = CCNT_W'(MAX_COLUMNS);
  localparam logic [ROWS_W:0]   ROWS_LIM_C = (ROWS_W + 1)'(ROWS_LIM);

  logic [ROWS_W-1:0]  rows_q;
  logic [COLS_W-1:0]  cols_q;
  logic [PAGE_W-1:0]  page_q;

  logic [COL_W-1:0]   col_q;
  logic [COL_W-1:0]   col_d;
  logic               phase_q;
  logic               phase_d;

  logic               accept;
  logic               scan_acc;
  logic               read_tick;
  logic               pass_end;
  logic [COL_W:0]     col_inc;
  logic [CCNT_W-1:0]  eff_cols;
  logic [ROWS_W:0]    rows_eff;
  logic [SENSE_W-1:0] sense;
  kmsd_map_wr_t       map_wr;

  logic [MAX_ROWS-1:0][KEY_BITS-1:0] lane_mask;
  logic [KEY_BITS-1:0]               keys;

  logic               out_valid_q;
  logic [DCOL_W-1:0]  dcol_q;
  logic               drive_q;
  logic               rv_q;
  logic [KEYS_W-1:0]  keys_q;
  logic [PAGE_W-1:0]  rpage_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= ROWS_RESET;
      cols_q <= COLS_RESET;
      page_q <= PAGE_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ROWS_IN_USE:    rows_q <= cfg_data_i[ROWS_W-1:0];
        CFG_COLUMNS_IN_USE: cols_q <= cfg_data_i[COLS_W-1:0];
        CFG_PAGE_NUMBER:    page_q <= cfg_data_i[PAGE_W-1:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign scan_acc      = accept && (s_axis_tuser == OP_SCAN);
  assign read_tick     = scan_acc && phase_q;
  assign sense         = s_axis_tdata[SENSE_W-1:0];

  assign map_wr.we    = accept && (s_axis_tuser == OP_MAP_WRITE);
  assign map_wr.index = s_axis_tdata[SENSE_W +: MAP_IDX_W];
  assign map_wr.key   = s_axis_tdata[SENSE_W+MAP_IDX_W +: MAP_KEY_W];

  always_comb begin
    if ({1'b0, cols_q} > MAX_COLS_C) begin
      eff_cols = MAX_COLS_C;
    end else if (cols_q == '0) begin
      eff_cols = CCNT_W'(1);
    end else begin
      eff_cols = CCNT_W'(cols_q);
    end
  end

  assign rows_eff = ({1'b0, rows_q} > ROWS_LIM_C) ? ROWS_LIM_C : {1'b0, rows_q};
  assign col_inc  = {1'b0, col_q} + (COL_W + 1)'(1);
  assign pass_end = read_tick && (CCNT_W'(col_inc) >= eff_cols);

  always_comb begin
    col_d   = col_q;
    phase_d = phase_q;
    if (scan_acc) begin
      phase_d = !phase_q;
      if (phase_q) begin
        col_d = pass_end ? '0 : COL_W'(col_inc);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      phase_q <= 1'b0;
    end else begin
      col_q   <= col_d;
      phase_q <= phase_d;
    end
  end

  for (genvar r = 0; r < MAX_ROWS; r++) begin : g_lane
    logic hit;
    if (r < ROWS_LIM) begin : g_sensed
      assign hit = read_tick && sense[r] && ((ROWS_W + 1)'(r) < rows_eff);
    end else begin : g_unsensed
      assign hit = 1'b0;
    end

    kmsd_lane #(
      .ROW         (r),
      .MAX_COLUMNS (MAX_COLUMNS),
      .KEY_BITS    (KEY_BITS),
      .COL_W       (COL_W)
    ) u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .wr_i      (map_wr),
      .rd_col_i  (col_d),
      .cur_col_i (col_q),
      .hit_i     (hit),
      .mask_o    (lane_mask[r])
    );
  end

  kmsd_ring #(
    .MAX_ROWS       (MAX_ROWS),
    .DEBOUNCE_SCANS (DEBOUNCE_SCANS),
    .KEY_BITS       (KEY_BITS)
  ) u_ring (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .masks_i    (lane_mask),
    .upd_i      (read_tick),
    .pass_end_i (pass_end),
    .keys_o     (keys)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      dcol_q  <= DCOL_W'(col_q);
      drive_q <= (s_axis_tuser == OP_MAP_WRITE) ? phase_q : !phase_q;
      rv_q    <= pass_end;
      keys_q  <= pass_end ? KEYS_W'(keys) : '0;
      rpage_q <= pass_end ? page_q : '0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = rv_q;
  assign m_axis_tdata  = {3'b000, rpage_q, keys_q, drive_q, dcol_q};

  `KMSD_ASSERT_NEXT(a_phase_flip, clk_i, rst_ni, scan_acc, phase_q != $past(phase_q))
  `KMSD_ASSERT_NEXT(a_pass_wrap, clk_i, rst_ni, pass_end, (col_q == '0) && !phase_q)
  `KMSD_ASSERT(a_report_undriven, clk_i, rst_ni, (m_axis_tvalid && m_axis_tuser) |-> !m_axis_tdata[4])

endmodule

@@ dv/tb_key_matrix_scan_debounce.sv @@
// testbench of the key matrix scanner: directed table, then random phases checked by a predictor
`timescale 1ns / 1ps
module tb_key_matrix_scan_debounce;
  import kmsd_pkg::*;

  localparam int NUM_ROWS    = 8;
  localparam int NUM_COLS    = 16;
  localparam int RING_DEPTH  = 4;
  localparam int MAP_DEPTH   = NUM_ROWS * NUM_COLS;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 190;
  localparam int HOLD_CYCLES = 64;
  localparam int DIR_ROWS    = 22;

  typedef struct packed {
    logic [DCOL_W-1:0] column;
    logic              drive_on;
    logic              report_valid;
    logic [KEYS_W-1:0] keys;
    logic [PAGE_W-1:0] page;
  } scan_report_t;

  typedef enum logic [1:0] {ROW_PREDICTED, ROW_TYPED, ROW_CFG} row_kind_e;
  typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  typedef struct packed {
    row_kind_e             kind;
    logic                  op;
    logic [SENSE_W-1:0]    sense;
    logic [MAP_IDX_W-1:0]  idx;
    logic [MAP_KEY_W-1:0]  key;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    scan_report_t          want;
  } stim_row_t;

  localparam scan_report_t NO_WANT = '0;

  localparam stim_row_t DIR_TABLE [DIR_ROWS] = '{
    '{ROW_TYPED, OP_SCAN, 8'h00, 7'd0, 7'd0, CFG_ROWS_IN_USE, 8'd0,
      '{4'd0, 1'b1, 1'b0, 64'd0, 8'd0}},
    '{ROW_TYPED, OP_MAP_WRITE, 8'h00, 7'd0, 7'd1, CFG_ROWS_IN_USE, 8'd0,
      '{4'd0, 1'b1, 1'b0, 64'd0, 8'd0}},
    // key number past the top sets nothing
    '{ROW_TYPED, OP_MAP_WRITE, 8'hff, 7'd127, 7'd127, CFG_ROWS_IN_USE, 8'd0,
      '{4'd0, 1'b1, 1'b0, 64'd0, 8'd0}},
    '{ROW_TYPED, OP_MAP_WRITE, 8'h00, 7'd16, 7'd64, CFG_ROWS_IN_USE, 8'd0,
      '{4'd0, 1'b1, 1'b0, 64'd0, 8'd0}},
    '{ROW_TYPED, OP_MAP_WRITE, 8'h00, 7'd1, 7'd0, CFG_ROWS_IN_USE, 8'd0,
      '{4'd0, 1'b1, 1'b0, 64'd0, 8'd0}},
    '{ROW_TYPED, OP_SCAN, 8'hff, 7'd0, 7'd0, CFG_ROWS_IN_USE, 8'd0,
      '{4'd0, 1'b0, 1'b0, 64'd0, 8'd0}},
    '{ROW_TYPED, OP_SCAN, 8'h00, 7'd0, 7'd0, CFG_ROWS_IN_USE, 8'd0,
      '{4'd1, 1'b1, 1'b0, 64'd0, 8'd0}},
    '{ROW_TYPED, OP_SCAN, 8'haa, 7'd0, 7'd0, CFG_ROWS_IN_USE, 8'd0,
      '{4'd1, 1'b0, 1'b0, 64'd0, 8'd0}},
    // column count dropped below the current column, zero acts as one
    '{ROW_CFG, OP_SCAN, 8'h00, 7'd0, 7'd0, CFG_COLUMNS_IN_USE, 8'd0, NO_WANT},
    '{ROW_CFG, OP_SCAN, 8'h00, 7'd0, 7'd0, CFG_PAGE_NUMBER, 8'hff, NO_WANT},
    '{ROW_CFG, OP_SCAN, 8'h00, 7'd0, 7'd0, CFG_ROWS_IN_USE, 8'd15, NO_WANT},
    '{ROW_TYPED, OP_SCAN, 8'h00, 7'd0, 7'd0, CFG_ROWS_IN_USE, 8'd0,
      '{4'd2, 1'b1, 1'b0, 64'd0, 8'd0}},
    '{ROW_TYPED, OP_SCAN, 8'hff, 7'd0, 7'd0, CFG_ROWS_IN_USE, 8'd0,
      '{4'd2, 1'b0, 1'b1, 64'd0, 8'hff}},
    '{ROW_PREDICTED, OP_SCAN, 8'h00, 7'd0, 7'd0, CFG_ROWS_IN_USE, 8'd0, NO_WANT},
    '{ROW_PREDICTED, OP_SCAN, 8'hff, 7'd0, 7'd0, CFG_ROWS_IN_USE, 8'd0, NO_WANT},
    '{ROW_PREDICTED, OP_SCAN, 8'h00, 7'd0, 7'd0, CFG_ROWS_IN_USE, 8'd0, NO_WANT},
    '{ROW_PREDICTED, OP_SCAN, 8'hff, 7'd0, 7'd0, CFG_ROWS_IN_USE, 8'd0, NO_WANT},
    '{ROW_PREDICTED, OP_SCAN, 8'h00, 7'd0, 7'd0, CFG_ROWS_IN_USE, 8'd0, NO_WANT},
    '{ROW_PREDICTED, OP_SCAN, 8'hff, 7'd0, 7'd0, CFG_ROWS_IN_USE, 8'd0, NO_WANT},
    // no rows sampled
    '{ROW_CFG, OP_SCAN, 8'h00, 7'd0, 7'd0, CFG_ROWS_IN_USE, 8'd0, NO_WANT},
    '{ROW_PREDICTED, OP_SCAN, 8'h00, 7'd0, 7'd0, CFG_ROWS_IN_USE, 8'd0, NO_WANT},
    '{ROW_PREDICTED, OP_SCAN, 8'hff, 7'd0, 7'd0, CFG_ROWS_IN_USE, 8'd0, NO_WANT}
  };

  localparam logic [CFG_DATA_W-1:0] ROWS_PICK [PHASES] = '{
    8'd8, 8'd15, 8'd1, 8'd8, 8'd0, 8'd4, 8'd8, 8'd2
  };
  localparam logic [CFG_DATA_W-1:0] COLS_PICK [PHASES] = '{
    8'd1, 8'd2, 8'd16, 8'd31, 8'd3, 8'd0, 8'd1, 8'd2
  };

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  // predictor state
  logic [ROWS_W-1:0]    rows_cfg = ROWS_RESET;
  logic [COLS_W-1:0]    cols_cfg = COLS_RESET;
  logic [PAGE_W-1:0]    page_cfg = PAGE_RESET;
  int                   column_pos = 0;
  logic                 reading = 1'b0;
  logic [KEYS_W-1:0]    slot_masks [RING_DEPTH] = '{default: '0};
  int                   slot_pos = 0;
  logic [MAP_KEY_W-1:0] key_table [MAP_DEPTH] = '{default: '0};

  scan_report_t expected_reports [$];
  int           mismatch_count = 0;
  int           sender_idle_pct = 0;
  int           receiver_stall_pct = 0;
  logic         pressure_req = 1'b0;
  logic         pressure_done = 1'b0;

  key_matrix_scan_debounce i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  function automatic logic [KEYS_W-1:0] key_to_bit(logic [MAP_KEY_W-1:0] k);
    if (k == 0 || k > KEYS_W) return '0;
    return {{(KEYS_W-1){1'b0}}, 1'b1} << (k - 1);
  endfunction

  function automatic int columns_effective();
    if (cols_cfg > NUM_COLS) return NUM_COLS;
    if (cols_cfg == 0) return 1;
    return int'(cols_cfg);
  endfunction

  function automatic scan_report_t predict_scan(logic op, logic [SENSE_W-1:0] sense,
                                                logic [MAP_IDX_W-1:0] idx,
                                                logic [MAP_KEY_W-1:0] key);
    scan_report_t rep;
    int rows;
    rep = '0;
    rep.column = DCOL_W'(column_pos);
    if (op == OP_MAP_WRITE) begin
      key_table[idx] = key;
      rep.drive_on = reading;
    end else if (!reading) begin
      rep.drive_on = 1'b1;
      reading = 1'b1;
    end else begin
      rows = (rows_cfg > NUM_ROWS) ? NUM_ROWS : int'(rows_cfg);
      for (int r = 0; r < rows; r++) begin
        if (sense[r]) slot_masks[slot_pos] |= key_to_bit(key_table[r * NUM_COLS + column_pos]);
      end
      column_pos++;
      if (column_pos >= columns_effective()) begin
        column_pos = 0;
        slot_pos = (slot_pos + 1) % RING_DEPTH;
        rep.keys = '1;
        for (int s = 0; s < RING_DEPTH; s++) rep.keys &= slot_masks[s];
        slot_masks[slot_pos] = '0;
        rep.report_valid = 1'b1;
        rep.page = page_cfg;
      end
      reading = 1'b0;
    end
    return rep;
  endfunction

  task automatic note_mismatch(string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic send_item(logic op, logic [SENSE_W-1:0] sense, logic [MAP_IDX_W-1:0] idx,
                           logic [MAP_KEY_W-1:0] key, output scan_report_t rep);
    cfg_valid_i <= 1'b0;
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= IN_DATA_W'({key, idx, sense});
    do @(posedge clk_i); while (!s_axis_tready);
    rep = predict_scan(op, sense, idx, key);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    s_axis_tvalid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_ROWS_IN_USE: begin
        rows_cfg = val[ROWS_W-1:0];
      end
      CFG_COLUMNS_IN_USE: begin
        cols_cfg = val[COLS_W-1:0];
      end
      CFG_PAGE_NUMBER: begin
        page_cfg = val[PAGE_W-1:0];
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_report();
    scan_report_t got, want;
    got.column       = m_axis_tdata[DCOL_W-1:0];
    got.drive_on     = m_axis_tdata[DCOL_W];
    got.keys         = m_axis_tdata[DCOL_W+1 +: KEYS_W];
    got.page         = m_axis_tdata[DCOL_W+1+KEYS_W +: PAGE_W];
    got.report_valid = m_axis_tuser;
    if (expected_reports.size() == 0) begin
      note_mismatch("result item with nothing expected");
      return;
    end
    want = expected_reports.pop_front();
    if (got.column != want.column)
      note_mismatch($sformatf("drive_column %0d, want %0d", got.column, want.column));
    if (got.drive_on != want.drive_on)
      note_mismatch($sformatf("drive_on %0b, want %0b", got.drive_on, want.drive_on));
    if (got.report_valid != want.report_valid)
      note_mismatch($sformatf("report_valid %0b, want %0b", got.report_valid,
                              want.report_valid));
    if (got.keys != want.keys)
      note_mismatch($sformatf("debounced_keys %h, want %h", got.keys, want.keys));
    if (got.page != want.page)
      note_mismatch($sformatf("report_page %0d, want %0d", got.page, want.page));
  endtask

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin : watchdog
    #5000000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : receiver
    int held;
    held = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) check_report();
      if (pressure_req && !pressure_done) begin
        m_axis_tready <= 1'b0;
        held++;
        if (held == HOLD_CYCLES) pressure_done = 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  initial begin : stimulus
    scan_report_t         rep;
    stim_row_t            row;
    idle_mode_e           mode;
    logic [SENSE_W-1:0]   held_rows [NUM_COLS];
    logic [SENSE_W-1:0]   sense;
    logic [MAP_IDX_W-1:0] idx;
    logic [MAP_KEY_W-1:0] key;
    logic [PAGE_W-1:0]    page;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIR_TABLE[i]) begin
      row = DIR_TABLE[i];
      if (row.kind == ROW_CFG) begin
        write_reg(row.reg_idx, row.reg_val);
      end else begin
        send_item(row.op, row.sense, row.idx, row.key, rep);
        expected_reports.push_back(row.kind == ROW_TYPED ? row.want : rep);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      page = (p == 0) ? 8'hff : (p == 1) ? 8'h00 : PAGE_W'($urandom_range(255));
      write_reg(CFG_ROWS_IN_USE, ROWS_PICK[p]);
      write_reg(CFG_COLUMNS_IN_USE, COLS_PICK[p]);
      write_reg(CFG_PAGE_NUMBER, page);
      mode = idle_mode_e'(p % 4);
      case (mode)
        IDLE_NONE: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 0;
        end
        IDLE_SENDER: begin
          sender_idle_pct = 72;
          receiver_stall_pct = 0;
        end
        IDLE_RECEIVER: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 72;
        end
        default: begin
          sender_idle_pct = 6;
          receiver_stall_pct = 6;
        end
      endcase
      foreach (held_rows[c]) held_rows[c] = SENSE_W'($urandom_range(255));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 0 && n == PHASE_ITEMS / 2) pressure_req = 1'b1;
        if (n < 16 || $urandom_range(99) < 5) begin
          idx = MAP_IDX_W'($urandom_range(MAP_DEPTH - 1));
          if ($urandom_range(99) < 70)
            idx = MAP_IDX_W'($urandom_range(NUM_ROWS - 1) * NUM_COLS
                             + $urandom_range(columns_effective() - 1));
          key = ($urandom_range(99) < 85) ? MAP_KEY_W'($urandom_range(KEYS_W, 1))
                                          : MAP_KEY_W'($urandom_range(127));
          send_item(OP_MAP_WRITE, SENSE_W'($urandom_range(255)), idx, key, rep);
        end else begin
          sense = SENSE_W'($urandom_range(255));
          if (reading && $urandom_range(99) < 90) begin
            // keys pressed or released now and then
            if ($urandom_range(99) < 3)
              held_rows[column_pos] ^= SENSE_W'(1 << $urandom_range(SENSE_W - 1));
            sense = held_rows[column_pos];
          end
          send_item(OP_SCAN, sense, MAP_IDX_W'($urandom_range(127)),
                    MAP_KEY_W'($urandom_range(127)), rep);
        end
        expected_reports.push_back(rep);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
